### design/hdw_pkg.sv
package hdw_pkg;

  // Sizing of the row store and of one sample.
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 16;

  localparam int NUM_LANES = 4;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 10;
  localparam int CH_W      = 16;
  localparam int REF_W     = 16;
  localparam int WORD_W    = REF_W + NUM_LANES * SAMPLE_BITS;

  // Register field widths.
  localparam int RW_W = 11;
  localparam int CC_W = 3;
  localparam int MS_W = 16;

  // APB port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Shift arithmetic: (ref - 32768) * max_shift, then Q8 pixel positions.
  localparam int DIFF_W  = REF_W + 1;
  localparam int PROD_W  = DIFF_W + MS_W + 1;
  localparam int SHIFT_W = PROD_W - 12;
  localparam int POS_W   = 16;
  localparam int FRAC_W  = 8;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_EMIT = 1'b1;

  localparam logic [RW_W-1:0] ROW_WIDTH_RST     = RW_W'(1024);
  localparam logic [CC_W-1:0] CHANNEL_COUNT_RST = CC_W'(4);
  localparam logic [MS_W-1:0] MAX_SHIFT_RST     = '0;
  localparam logic            ALPHA_WARP_RST    = 1'b0;
  localparam logic            SMOOTH_RST        = 1'b1;

  typedef enum logic [2:0] {
    REG_ROW_WIDTH     = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_MAX_SHIFT     = 3'd2,
    REG_ALPHA_WARP    = 3'd3,
    REG_SMOOTH        = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              action;
    logic [COL_W-1:0]  column;
    logic [CH_W-1:0]   in_ch0;
    logic [CH_W-1:0]   in_ch1;
    logic [CH_W-1:0]   in_ch2;
    logic [CH_W-1:0]   in_ch3;
    logic [REF_W-1:0]  ref_level;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_ch0;
    logic [CH_W-1:0]   out_ch1;
    logic [CH_W-1:0]   out_ch2;
    logic [CH_W-1:0]   out_ch3;
    logic [COL_W-1:0]  out_column;
  } out_res_t;

  typedef struct packed {
    logic [RW_W-1:0] row_width;
    logic [CC_W-1:0] channel_count;
    logic [MS_W-1:0] max_shift;
    logic            alpha_warp;
    logic            smooth;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [FRAC_W-1:0] frac;
  } pos_t;

endpackage

### design/hdw_ram.sv
module hdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### design/hdw_cfg.sv
module hdw_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hdw_pkg::PADDR_W-1:0]  paddr,
  input  logic [hdw_pkg::PDATA_W-1:0]  pwdata,
  output logic [hdw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output hdw_pkg::cfg_t                cfg
);
  import hdw_pkg::*;

  logic [RW_W-1:0] row_width_r;
  logic [CC_W-1:0] channel_count_r;
  logic [MS_W-1:0] max_shift_r;
  logic            alpha_warp_r;
  logic            smooth_r;
  logic            wr_en;
  reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= ROW_WIDTH_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
      max_shift_r     <= MAX_SHIFT_RST;
      alpha_warp_r    <= ALPHA_WARP_RST;
      smooth_r        <= SMOOTH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ROW_WIDTH:     row_width_r     <= pwdata[RW_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= pwdata[CC_W-1:0];
        REG_MAX_SHIFT:     max_shift_r     <= pwdata[MS_W-1:0];
        REG_ALPHA_WARP:    alpha_warp_r    <= pwdata[0];
        REG_SMOOTH:        smooth_r        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_WIDTH:     prdata = PDATA_W'(row_width_r);
      REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_r);
      REG_MAX_SHIFT:     prdata = PDATA_W'(max_shift_r);
      REG_ALPHA_WARP:    prdata = PDATA_W'(alpha_warp_r);
      REG_SMOOTH:        prdata = PDATA_W'(smooth_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.row_width     = row_width_r;
  assign cfg.channel_count = channel_count_r;
  assign cfg.max_shift     = max_shift_r;
  assign cfg.alpha_warp    = alpha_warp_r;
  assign cfg.smooth        = smooth_r;

endmodule

### design/hdw_pos.sv
module hdw_pos (
  input  logic signed [hdw_pkg::PROD_W-1:0] prod,
  input  logic [hdw_pkg::COL_W-1:0]         col,
  input  hdw_pkg::cfg_t                     cfg,
  output hdw_pkg::pos_t                     pos
);
  import hdw_pkg::*;

  localparam int RND_W = SHIFT_W + 1;
  localparam int IDX_W = RND_W - FRAC_W;

  logic signed [SHIFT_W-1:0] shift;
  logic signed [RND_W-1:0]   rnd;
  logic signed [IDX_W-1:0]   step;
  logic [FRAC_W-1:0]         frac;
  logic signed [POS_W-1:0]   lo_s;
  logic signed [POS_W-1:0]   hi_s;
  logic signed [POS_W-1:0]   w;

  // Arithmetic right shifts give floor division for negative shifts.
  assign shift = SHIFT_W'(prod >>> 12);
  assign rnd   = cfg.smooth ? RND_W'(shift) : RND_W'(shift) + RND_W'(128);
  assign step  = IDX_W'(rnd >>> FRAC_W);
  assign frac  = cfg.smooth ? shift[FRAC_W-1:0] : '0;

  assign lo_s = $signed({{(POS_W-COL_W){1'b0}}, col}) + POS_W'(step);
  assign hi_s = lo_s + POS_W'(frac != '0);

  always_comb begin
    if (cfg.row_width == '0) begin
      w = POS_W'(1);
    end else if (POS_W'(cfg.row_width) > POS_W'(MAX_WIDTH)) begin
      w = POS_W'(MAX_WIDTH);
    end else begin
      w = POS_W'(cfg.row_width);
    end
  end

  function automatic logic [ADDR_W-1:0] clamp(input logic signed [POS_W-1:0] p,
                                              input logic signed [POS_W-1:0] lim);
    logic [ADDR_W-1:0] r;
    if (p < 0) begin
      r = '0;
    end else if (p >= lim) begin
      r = ADDR_W'(lim - POS_W'(1));
    end else begin
      r = ADDR_W'(p);
    end
    return r;
  endfunction

  assign pos.lo   = clamp(lo_s, w);
  assign pos.hi   = clamp(hi_s, w);
  assign pos.frac = frac;

endmodule

### design/hdw_blend.sv
module hdw_blend (
  input  logic [hdw_pkg::WORD_W-1:0]      word_a,
  input  logic [hdw_pkg::WORD_W-1:0]      word_b,
  input  logic [hdw_pkg::SAMPLE_BITS-1:0] alpha,
  input  logic [hdw_pkg::FRAC_W-1:0]      frac,
  input  hdw_pkg::cfg_t                   cfg,
  output logic [hdw_pkg::NUM_LANES-1:0][hdw_pkg::CH_W-1:0] samples
);
  import hdw_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int DF_W  = SB + 1;
  localparam int MUL_W = DF_W + FRAC_W + 1;
  localparam int ACC_W = MUL_W + 1;

  logic [CC_W-1:0] nch;

  always_comb begin
    if (cfg.channel_count == '0) begin
      nch = CC_W'(1);
    end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
      nch = CC_W'(MAX_CHANNELS);
    end else begin
      nch = cfg.channel_count;
    end
  end

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    logic [SB-1:0]           a;
    logic [SB-1:0]           b;
    logic signed [DF_W-1:0]  df;
    logic signed [MUL_W-1:0] mul;
    logic signed [ACC_W-1:0] acc;
    logic [SB-1:0]           mix;

    assign a = word_a[c*SB +: SB];
    assign b = word_b[c*SB +: SB];
    // a*(256-f) + b*f + 128 written as a*256 + (b-a)*f + 128.
    assign df  = $signed({1'b0, b}) - $signed({1'b0, a});
    assign mul = MUL_W'(df * $signed({1'b0, frac}));
    assign acc = $signed(ACC_W'({a, {FRAC_W{1'b0}}})) + ACC_W'(mul) + ACC_W'(128);
    assign mix = acc[FRAC_W +: SB];

    always_comb begin
      if (CC_W'(c) >= nch) begin
        samples[c] = '0;
      end else if (c == NUM_LANES - 1 && !cfg.alpha_warp) begin
        samples[c] = CH_W'(alpha);
      end else begin
        samples[c] = CH_W'(mix);
      end
    end
  end

endmodule

### design/horizontal_displacement_warp.sv
// A load request leaves the block idle; the next request may enter on the following cycle.
// Emit requests keep the block busy until their result is in the output register and
// pass through row store read, shift multiply, neighbor read and blend, in that order.
// A finished result waits in the output register while the next request enters.
// rst_n is synchronous and active low; it clears control state and the configuration
// registers to their defaults. The row store is not cleared.
module horizontal_displacement_warp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hdw_pkg::in_req_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hdw_pkg::out_res_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hdw_pkg::PADDR_W-1:0]  paddr,
  input  logic [hdw_pkg::PDATA_W-1:0]  pwdata,
  output logic [hdw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import hdw_pkg::*;

  // The sequencer walks one emit request through the stages below. Only one
  // request is in flight, so a load can never write an entry that an emit
  // still has to read and no forwarding is needed.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_POS,
    S_BLEND
  } state_t;

  state_t state_r, state_nxt;

  cfg_t cfg;
  pos_t pos;

  logic [COL_W-1:0]         col_r, col_nxt;
  logic [SAMPLE_BITS-1:0]   alpha_r, alpha_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [FRAC_W-1:0]        frac_r, frac_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_res_t                 out_data_r, out_data_nxt;

  logic                     accept;
  logic [ADDR_W-1:0]        at_addr;
  logic                     in_range;
  logic [WORD_W-1:0]        wr_word;
  logic                     we;
  logic                     re_a, re_b;
  logic [ADDR_W-1:0]        raddr_a, raddr_b;
  logic [WORD_W-1:0]        rd_a, rd_b;
  logic signed [DIFF_W-1:0] ref_diff;
  logic [NUM_LANES-1:0][CH_W-1:0] samples;

  hdw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // One word per column: reference level on top, then the four samples.
  hdw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_row (
    .clk     (clk),
    .we      (we),
    .waddr   (at_addr),
    .wdata   (wr_word),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  hdw_pos u_pos (
    .prod (prod_r),
    .col  (col_r),
    .cfg  (cfg),
    .pos  (pos)
  );

  hdw_blend u_blend (
    .word_a  (rd_a),
    .word_b  (rd_b),
    .alpha   (alpha_r),
    .frac    (frac_r),
    .cfg     (cfg),
    .samples (samples)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Columns past the store map onto its last entry for reads and are not written.
  assign in_range = int'(in_data.column) < MAX_WIDTH;
  assign at_addr  = in_range ? ADDR_W'(in_data.column) : ADDR_W'(MAX_WIDTH - 1);

  assign wr_word = {in_data.ref_level,
                    in_data.in_ch3[SAMPLE_BITS-1:0], in_data.in_ch2[SAMPLE_BITS-1:0],
                    in_data.in_ch1[SAMPLE_BITS-1:0], in_data.in_ch0[SAMPLE_BITS-1:0]};
  assign we = accept && in_data.action == ACTION_LOAD && in_range;

  // Signed offset of the stored reference level from the no-shift center.
  assign ref_diff = $signed({1'b0, rd_a[WORD_W-1 -: REF_W]}) - $signed(DIFF_W'(32768));

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    alpha_nxt     = alpha_r;
    prod_nxt      = prod_r;
    frac_nxt      = frac_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    re_a          = 1'b0;
    re_b          = 1'b0;
    raddr_a       = at_addr;
    raddr_b       = pos.hi;

    case (state_r)
      S_IDLE: begin
        // An emit first reads its own column for the reference and the alpha.
        if (accept && in_data.action == ACTION_EMIT) begin
          re_a      = 1'b1;
          col_nxt   = in_data.column;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        alpha_nxt = rd_a[(NUM_LANES-1)*SAMPLE_BITS +: SAMPLE_BITS];
        prod_nxt  = PROD_W'(ref_diff * $signed({1'b0, cfg.max_shift}));
        state_nxt = S_POS;
      end
      S_POS: begin
        // Both neighbors come out of the two read ports in the same cycle.
        re_a      = 1'b1;
        re_b      = 1'b1;
        raddr_a   = pos.lo;
        raddr_b   = pos.hi;
        frac_nxt  = pos.frac;
        state_nxt = S_BLEND;
      end
      S_BLEND: begin
        // Read data holds while the output register is still occupied.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.out_ch0    = samples[0];
          out_data_nxt.out_ch1    = samples[1];
          out_data_nxt.out_ch2    = samples[2];
          out_data_nxt.out_ch3    = samples[3];
          out_data_nxt.out_column = col_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r      <= col_nxt;
    alpha_r    <= alpha_nxt;
    prod_r     <= prod_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### design/hdw_checker.sv
module hdw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input hdw_pkg::in_req_t             in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input hdw_pkg::out_res_t            out_data
);
  import hdw_pkg::*;

  logic load_acc, emit_acc;

  assign load_acc = in_valid && in_ready && in_data.action == ACTION_LOAD;
  assign emit_acc = in_valid && in_ready && in_data.action == ACTION_EMIT;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc && !out_valid |=> !out_valid)
    else $error("load request produced a result");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> in_ready)
    else $error("block busy after a load request");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit_acc |=> !in_ready)
    else $error("request taken while an emit is in flight");

  a_emit_lat: assert property (@(posedge clk) disable iff (!rst_n)
    emit_acc && !out_valid |-> ##4 out_valid)
    else $error("emit result not presented after four cycles");

endmodule

bind horizontal_displacement_warp hdw_checker u_hdw_checker (.*);

### test/horizontal_displacement_warp_test.sv
`timescale 1ns / 100ps

module horizontal_displacement_warp_test;
  import hdw_pkg::*;

  // Kinds of rows in the directed script: a register write or a request.
  typedef enum logic {
    STEP_WRITE_REG,
    STEP_REQUEST
  } step_kind_t;

  // One row of the directed script. Rows with typed set carry an expected
  // pixel that is obvious by inspection; all other emits use the predictor.
  typedef struct {
    step_kind_t  kind;
    reg_idx_t    idx;
    logic [31:0] value;
    in_req_t     req;
    bit          typed;
    out_res_t    want;
  } script_row_t;

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 152;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 8;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_req_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_res_t            out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  horizontal_displacement_warp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the row stores and of the registers. The row stores are
  // updated when a load request is accepted; col_loaded tracks which entries
  // hold real data, so that no emit ever reads an entry never written.
  logic [CH_W-1:0]  row_pix [MAX_WIDTH][NUM_LANES];
  logic [REF_W-1:0] row_lvl [MAX_WIDTH];
  bit               col_loaded [MAX_WIDTH];
  cfg_t             shadow_cfg;

  // Warped pixels still owed by the block, oldest first.
  out_res_t pending_pixels [$];
  out_res_t oldest_pixel;

  int failures      = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_taken   = 0;
  int hold_left     = 0;

  script_row_t script [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #5000000;
    $display("horizontal_displacement_warp regression: fail");
    $finish;
  end

  // Register fields outside their legal range are folded the same way the
  // block does it: zero acts as the minimum, anything above the store size
  // or lane count acts as the maximum.
  function automatic int eff_width();
    int w;
    w = int'(shadow_cfg.row_width);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_channels();
    int n;
    n = int'(shadow_cfg.channel_count);
    if (n < 1) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    return n;
  endfunction

  // Source positions for one output column. The shift is Q8 pixels and is
  // floored; in smooth mode the fraction selects between floor and ceil,
  // in nearest mode half a pixel is added before flooring (half rounds up).
  function automatic void locate_source(input int col, input logic [REF_W-1:0] lvl,
                                        output int lo, output int hi, output int frac);
    longint prod;
    longint shift;
    int     w;
    w = eff_width();
    prod = (longint'(lvl) - 32768) * longint'(shadow_cfg.max_shift);
    shift = prod >>> 12;
    if (shadow_cfg.smooth) begin
      frac = int'(shift & 255);
      lo = col + int'(shift >>> 8);
      hi = lo + (frac != 0 ? 1 : 0);
    end else begin
      frac = 0;
      lo = col + int'((shift + 128) >>> 8);
      hi = lo;
    end
    if (lo < 0) lo = 0;
    if (lo >= w) lo = w - 1;
    if (hi < 0) hi = 0;
    if (hi >= w) hi = w - 1;
  endfunction

  // Expected output pixel for an emit at col. Unused lanes read as zero and
  // alpha is taken from the emitted column itself unless it is warped too.
  function automatic out_res_t warp_pixel(input logic [COL_W-1:0] col);
    int       lo, hi, frac, nch, a, b;
    int       v [NUM_LANES];
    out_res_t px;
    locate_source(int'(col), row_lvl[col], lo, hi, frac);
    nch = eff_channels();
    for (int c = 0; c < NUM_LANES; c++) begin
      v[c] = 0;
      if (c < nch) begin
        if (c == 3 && !shadow_cfg.alpha_warp) begin
          v[c] = int'(row_pix[col][c]);
        end else begin
          a = int'(row_pix[lo][c]);
          b = int'(row_pix[hi][c]);
          v[c] = (a * (256 - frac) + b * frac + 128) >> 8;
        end
      end
    end
    px.out_ch0    = CH_W'(v[0]);
    px.out_ch1    = CH_W'(v[1]);
    px.out_ch2    = CH_W'(v[2]);
    px.out_ch3    = CH_W'(v[3]);
    px.out_column = col;
    return px;
  endfunction

  // An emit is only legal when every store entry it touches has been loaded.
  function automatic bit emit_is_safe(input int col);
    int lo, hi, frac;
    if (!col_loaded[col]) return 1'b0;
    locate_source(col, row_lvl[col], lo, hi, frac);
    return col_loaded[lo] && col_loaded[hi];
  endfunction

  function automatic in_req_t load_req(input int col, input logic [15:0] c0,
                                       input logic [15:0] c1, input logic [15:0] c2,
                                       input logic [15:0] c3, input logic [15:0] lvl);
    in_req_t r;
    r.action    = ACTION_LOAD;
    r.column    = COL_W'(col);
    r.in_ch0    = c0;
    r.in_ch1    = c1;
    r.in_ch2    = c2;
    r.in_ch3    = c3;
    r.ref_level = lvl;
    return r;
  endfunction

  // Emits carry random junk in the sample and level fields, which the block
  // must ignore.
  function automatic in_req_t emit_req(input int col);
    in_req_t r;
    r = load_req(col, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    r.action = ACTION_EMIT;
    return r;
  endfunction

  function automatic script_row_t step_cfg(input reg_idx_t idx, input int value);
    script_row_t s;
    s = '{STEP_WRITE_REG, idx, 32'(value), '0, 1'b0, '0};
    return s;
  endfunction

  function automatic script_row_t step_load(input int col, input logic [15:0] c0,
                                            input logic [15:0] c1, input logic [15:0] c2,
                                            input logic [15:0] c3, input logic [15:0] lvl);
    script_row_t s;
    s = '{STEP_REQUEST, REG_ROW_WIDTH, 32'd0, load_req(col, c0, c1, c2, c3, lvl), 1'b0, '0};
    return s;
  endfunction

  function automatic script_row_t step_emit(input int col);
    script_row_t s;
    s = '{STEP_REQUEST, REG_ROW_WIDTH, 32'd0, emit_req(col), 1'b0, '0};
    return s;
  endfunction

  function automatic script_row_t step_emit_is(input int col, input logic [15:0] c0,
                                               input logic [15:0] c1, input logic [15:0] c2,
                                               input logic [15:0] c3);
    script_row_t s;
    s = step_emit(col);
    s.typed = 1'b1;
    s.want  = '{c0, c1, c2, c3, COL_W'(col)};
    return s;
  endfunction

  // Reference levels: mostly close to the no-shift point so that small
  // displacements and fractions are common, plus full-range and extremes.
  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(32768 + int'($urandom_range(0, 511)) - 256);
      2: return 16'(32768 + int'($urandom_range(0, 8191)) - 4096);
      default: begin
        case ($urandom_range(0, 2))
          0: return 16'h0000;
          1: return 16'hFFFF;
          default: return 16'h8000;
        endcase
      end
    endcase
  endfunction

  // Offers one request and waits for it to be taken. Called and returning at
  // a falling edge; valid stays high on return so a following request can
  // go out back to back without valid dropping.
  task automatic send_item(input in_req_t r, input bit typed, input out_res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (r.action == ACTION_LOAD) begin
      row_pix[r.column]    = '{r.in_ch0, r.in_ch1, r.in_ch2, r.in_ch3};
      row_lvl[r.column]    = r.ref_level;
      col_loaded[r.column] = 1'b1;
    end else begin
      pending_pixels.push_back(typed ? want : warp_pixel(r.column));
    end
    @(negedge clk);
  endtask

  // Drains the block: waits for all owed pixels to come back, then lets it settle;
  // a trailing load gives no result and is written when it is accepted.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is tied high, so the
  // register takes the value at the rising edge inside the access cycle.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW_WIDTH:     shadow_cfg.row_width     = value[RW_W-1:0];
      REG_CHANNEL_COUNT: shadow_cfg.channel_count = value[CC_W-1:0];
      REG_MAX_SHIFT:     shadow_cfg.max_shift     = value[MS_W-1:0];
      REG_ALPHA_WARP:    shadow_cfg.alpha_warp    = value[0];
      REG_SMOOTH:        shadow_cfg.smooth        = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Well-formed traffic: load a run of adjacent columns of the current row,
  // then emit columns inside that run, with the odd emit anywhere else.
  task automatic row_burst();
    int w, n, s, m, col;
    w = eff_width();
    n = $urandom_range(1, (w < 24) ? w : 24);
    s = $urandom_range(0, w - n);
    for (int i = 0; i < n; i++) begin
      send_item(load_req(s + i, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), pick_level()), 1'b0, '0);
    end
    m = $urandom_range(1, n + 2);
    for (int i = 0; i < m; i++) begin
      col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_WIDTH - 1)
                                         : s + $urandom_range(0, n - 1);
      if (emit_is_safe(col)) send_item(emit_req(col), 1'b0, '0);
    end
  endtask

  // Noise: loads anywhere in the store and emits at arbitrary columns.
  task automatic noise_item();
    int col;
    col = $urandom_range(0, MAX_WIDTH - 1);
    if ($urandom_range(0, 2) == 0 && emit_is_safe(col))
      send_item(emit_req(col), 1'b0, '0);
    else
      send_item(load_req(col, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom)), 1'b0, '0);
  endtask

  // Each random phase gets a full set of register values. The first phases
  // pin the row width to its extremes and set fixed channel counts, including the
  // out-of-range encodings; later ones pick mostly small rows.
  task automatic configure_phase(input int k);
    int rw, cc, ms;
    wait_idle();
    case (k)
      0: rw = 1;
      1: rw = MAX_WIDTH;
      2: rw = 0;
      3: rw = 2047;
      default: rw = ($urandom_range(0, 3) == 0) ? $urandom_range(49, MAX_WIDTH)
                                                 : $urandom_range(2, 48);
    endcase
    case (k)
      0: cc = 4;
      1: cc = 1;
      2: cc = 2;
      3: cc = 3;
      4: cc = 0;
      5: cc = 7;
      6: cc = 5;
      default: cc = $urandom_range(1, 4);
    endcase
    case (k % 4)
      0: ms = 65535;
      1: ms = 0;
      2: ms = $urandom_range(0, 4096);
      default: ms = $urandom_range(0, 65535);
    endcase
    write_reg(REG_ROW_WIDTH, rw);
    write_reg(REG_CHANNEL_COUNT, cc);
    write_reg(REG_MAX_SHIFT, ms);
    write_reg(REG_ALPHA_WARP, (k < 4) ? k % 2 : $urandom_range(0, 1));
    write_reg(REG_SMOOTH, (k < 4) ? (k / 2) % 2 : $urandom_range(0, 1));
    // Rotate through the four idling patterns; each phase gets one of
    // them.
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 46; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // Result side: outside a hold-off, ready is redrawn every cycle. A hold-off request makes the
  // receiver refuse results for a long stretch while requests keep coming,
  // so the pipeline fills and in_ready has to drop.
  always @(negedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // Every accepted result is matched against the oldest owed pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("result for column %0h arrived with nothing pending", out_data.out_column);
        failures++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        check_field("out_ch0", 32'(oldest_pixel.out_ch0), 32'(out_data.out_ch0));
        check_field("out_ch1", 32'(oldest_pixel.out_ch1), 32'(out_data.out_ch1));
        check_field("out_ch2", 32'(oldest_pixel.out_ch2), 32'(out_data.out_ch2));
        check_field("out_ch3", 32'(oldest_pixel.out_ch3), 32'(out_data.out_ch3));
        check_field("out_column", 32'(oldest_pixel.out_column), 32'(out_data.out_column));
      end
    end
  end

  initial begin
    int target;

    shadow_cfg = '{ROW_WIDTH_RST, CHANNEL_COUNT_RST, MAX_SHIFT_RST, ALPHA_WARP_RST,
                   SMOOTH_RST};
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_loaded[i] = 1'b0;
      row_lvl[i]    = '0;
      row_pix[i]    = '{default: '0};
    end

    // Directed part. With the reset settings the shift is zero, so every
    // emit simply returns the pixel loaded at its own column. After that the
    // row shrinks to three pixels with the widest span: full-scale levels
    // clamp at both edges, levels just off center give small fractions, then
    // nearest mode with the channel count at zero (acts as one), and last a
    // zero row width with an oversized channel count and alpha passthrough.
    script = '{
      step_load(0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
      step_load(1,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      step_load(2,    16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h8000),
      step_load(1023, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000),
      step_load(1022, 16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0, 16'h7FFF),
      step_emit_is(0,    16'h0000, 16'h0000, 16'h0000, 16'h0000),
      step_emit_is(1,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      step_emit_is(1023, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000),
      step_emit_is(1022, 16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0),
      step_emit_is(2,    16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0),
      step_cfg(REG_ROW_WIDTH, 3),
      step_cfg(REG_MAX_SHIFT, 65535),
      step_cfg(REG_ALPHA_WARP, 1),
      step_emit(0),
      step_emit(1),
      step_emit(2),
      step_load(1, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8003),
      step_emit(1),
      step_load(0, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h7FFD),
      step_emit(0),
      step_cfg(REG_SMOOTH, 0),
      step_cfg(REG_CHANNEL_COUNT, 0),
      step_emit(0),
      step_emit(1),
      step_emit(2),
      step_cfg(REG_CHANNEL_COUNT, 7),
      step_cfg(REG_ALPHA_WARP, 0),
      step_cfg(REG_ROW_WIDTH, 0),
      step_emit(1)
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE_REG) begin
        wait_idle();
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_item(script[i].req, script[i].typed, script[i].want);
      end
    end

    // Random part: mostly row bursts, the rest noise. One phase also parks
    // the receiver for a long stretch to back the pipeline up.
    for (int k = 0; k < NUM_PHASES; k++) begin
      configure_phase(k);
      if (k == 5) hold_requests++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 70) row_burst();
        else noise_item();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (failures == 0)
      $display("horizontal_displacement_warp regression: pass");
    else
      $display("horizontal_displacement_warp regression: fail");
    $finish;
  end

endmodule

### files.f
design/hdw_pkg.sv
design/hdw_ram.sv
design/hdw_cfg.sv
design/hdw_pos.sv
design/hdw_blend.sv
design/horizontal_displacement_warp.sv
design/hdw_checker.sv
test/horizontal_displacement_warp_test.sv
